>>> sv/command_frame_builder_crc16_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef COMMAND_FRAME_BUILDER_CRC16_MACROS_SVH
`define COMMAND_FRAME_BUILDER_CRC16_MACROS_SVH

// same-cycle implication
`define CFB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CFB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/cfb_pkg.sv
// ----------------------------------------------------------------------------
// cfb_pkg
// Types and constants of the command frame builder.
// ----------------------------------------------------------------------------
package cfb_pkg;

    localparam int MAX_PAIRS   = 4;
    localparam int PAIR_REGS   = 4;
    localparam int PAIR_LIMIT  = (MAX_PAIRS < PAIR_REGS) ? MAX_PAIRS : PAIR_REGS;
    localparam int PAIR_IDX_W  = $clog2(PAIR_REGS);
    localparam int N_W         = 3;
    localparam int IDX_W       = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0]  HDR_A         = 8'hFF;
    localparam logic [7:0]  HDR_B         = 8'hFD;
    localparam logic [15:0] CRC_POLY_REFL = 16'h8408;

    localparam logic [3:0] INSTR_DIRECTION = 4'd1;
    localparam logic [3:0] INSTR_TURN      = 4'd2;
    localparam logic [3:0] INSTR_RESET     = 4'd3;

    localparam logic [7:0] TYPE_DIRECTION = 8'h49;
    localparam logic [7:0] TYPE_TURN      = 8'h02;
    localparam logic [7:0] TYPE_RESET     = 8'h03;
    localparam logic [7:0] TYPE_NONE      = 8'h00;

    localparam logic [N_W-1:0]        PAIR_COUNT_RST = 3'd1;
    localparam logic [CFG_DATA_W-1:0] PAIR_WORD0_RST = 16'h414F;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAIR_COUNT  = 3'd0,
        CFG_PAIR_WORD_0 = 3'd1,
        CFG_PAIR_WORD_1 = 3'd2,
        CFG_PAIR_WORD_2 = 3'd3,
        CFG_PAIR_WORD_3 = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [PAIR_REGS-1:0][CFG_DATA_W-1:0] pair_word;
    } cfg_t;

    typedef struct packed {
        logic [7:0]     id;
        logic [7:0]     ty;
        logic [N_W-1:0] n;
    } entry_t;

endpackage

>>> sv/cfb_front.sv
// ----------------------------------------------------------------------------
// cfb_front
// Configuration registers, command decode and pair count saturation.
// ----------------------------------------------------------------------------
module cfb_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cfb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cfb_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    frame_id,
    input  logic [3:0]                    instruction_code,
    output logic                          push_valid,
    input  logic                          push_ready,
    output cfb_pkg::entry_t               push_entry,
    output cfb_pkg::cfg_t                 cfg
);
    import cfb_pkg::*;

    logic [N_W-1:0] pair_count_reg;
    cfg_t           cfg_reg;
    logic [N_W-1:0] n_sat;
    logic [7:0]     ty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_count_reg <= PAIR_COUNT_RST;
            cfg_reg.pair_word[PAIR_REGS-1:1] <= '0;
            cfg_reg.pair_word[0] <= PAIR_WORD0_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PAIR_COUNT:  pair_count_reg <= cfg_data[N_W-1:0];
                CFG_PAIR_WORD_0: cfg_reg.pair_word[0] <= cfg_data;
                CFG_PAIR_WORD_1: cfg_reg.pair_word[1] <= cfg_data;
                CFG_PAIR_WORD_2: cfg_reg.pair_word[2] <= cfg_data;
                CFG_PAIR_WORD_3: cfg_reg.pair_word[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (instruction_code)
            INSTR_DIRECTION: ty = TYPE_DIRECTION;
            INSTR_TURN:      ty = TYPE_TURN;
            INSTR_RESET:     ty = TYPE_RESET;
            default:         ty = TYPE_NONE;
        endcase
        n_sat = (pair_count_reg > N_W'(PAIR_LIMIT)) ? N_W'(PAIR_LIMIT) : pair_count_reg;
    end

    assign in_ready      = push_ready;
    assign push_valid    = in_valid;
    assign push_entry.id = frame_id;
    assign push_entry.ty = ty;
    assign push_entry.n  = n_sat;
    assign cfg           = cfg_reg;

endmodule

>>> sv/cfb_queue.sv
// ----------------------------------------------------------------------------
// cfb_queue
// Small FIFO of decoded commands between front and back.
// ----------------------------------------------------------------------------
module cfb_queue
#(
    parameter int DEPTH = cfb_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  cfb_pkg::entry_t push_entry,
    output logic            pop_valid,
    input  logic            pop,
    output cfb_pkg::entry_t pop_entry
);
    import cfb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

>>> sv/cfb_back.sv
// ----------------------------------------------------------------------------
// cfb_back
// Byte sequencer with running CRC-16/KERMIT and registered output.
// ----------------------------------------------------------------------------
module cfb_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_pop,
    input  cfb_pkg::entry_t q_entry,
    input  cfb_pkg::cfg_t   cfg,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      frame_byte,
    output logic            last_byte
);
    import cfb_pkg::*;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
        return c;
    endfunction

    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [15:0]      crc_reg, crc_next;
    entry_t           entry_reg, entry_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;

    logic             advance, step, load, is_last, in_crc;
    logic [IDX_W-1:0] end_idx, last_idx, pair_off;
    logic [15:0]      word;
    logic [7:0]       cur_byte;

    always_comb
    begin
        end_idx  = {entry_reg.n, 1'b0} + IDX_W'(6);
        last_idx = end_idx + 1'b1;
        pair_off = idx_reg - IDX_W'(6);
        word     = cfg.pair_word[pair_off[PAIR_IDX_W:1]];
        is_last  = (idx_reg == last_idx);
        in_crc   = (idx_reg >= IDX_W'(4)) && (idx_reg < end_idx);

        case (idx_reg)
            4'd0, 4'd1: cur_byte = HDR_A;
            4'd2:       cur_byte = HDR_B;
            4'd3:       cur_byte = {4'h0, end_idx} - 8'd1;
            4'd4:       cur_byte = entry_reg.id;
            4'd5:       cur_byte = entry_reg.ty;
            default:
            begin
                if (idx_reg == end_idx)
                    cur_byte = crc_reg[7:0];
                else if (is_last)
                    cur_byte = crc_reg[15:8];
                else
                    cur_byte = pair_off[0] ? word[7:0] : word[15:8];
            end
        endcase

        advance = !out_valid_reg || out_ready;
        step    = busy_reg && advance;
        load    = q_valid && (!busy_reg || (step && is_last));
        q_pop   = load;

        busy_next      = busy_reg;
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        entry_next     = entry_reg;
        out_valid_next = out_valid_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;

        if (advance)
            out_valid_next = 1'b0;
        if (step)
        begin
            out_valid_next = 1'b1;
            byte_next      = cur_byte;
            last_next      = is_last;
            idx_next       = idx_reg + 1'b1;
            if (in_crc)
                crc_next = crc_byte(crc_reg, cur_byte);
            if (is_last)
                busy_next = 1'b0;
        end
        if (load)
        begin
            busy_next  = 1'b1;
            idx_next   = '0;
            crc_next   = '0;
            entry_next = q_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg   <= crc_next;
        entry_reg <= entry_next;
        byte_reg  <= byte_next;
        last_reg  <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = byte_reg;
    assign last_byte  = last_reg;

endmodule

>>> sv/command_frame_builder_crc16.sv
// ----------------------------------------------------------------------------
// command_frame_builder_crc16
// Builds one CRC-16/KERMIT protected command frame per accepted command.
//
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
// in        in         in_valid/in_ready      frame_id, instruction_code
// out       out        out_valid/out_ready    frame_byte, last_byte
//
// A frame is 8 + 2n bytes, one per cycle from the byte sequencer unless
// out_ready holds it; frames follow each other with no gap while commands
// wait in the queue. Commands are taken while the queue has room, and a
// frame byte waits in the output register while out_ready is low. cfg_ready
// is always high. Reset restores register defaults and empties the queue.
// ----------------------------------------------------------------------------
module command_frame_builder_crc16
#(
    parameter int QUEUE_DEPTH = cfb_pkg::QUEUE_DEPTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cfb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cfb_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     frame_id,
    input  logic [3:0]                     instruction_code,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     frame_byte,
    output logic                           last_byte
);
    import cfb_pkg::*;

    logic   push_valid, push_ready, q_valid, q_pop;
    entry_t push_entry, q_entry;
    cfg_t   cfg;

    cfb_front u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .frame_id         (frame_id),
        .instruction_code (instruction_code),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_entry       (push_entry),
        .cfg              (cfg)
    );

    cfb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_entry  (q_entry)
    );

    cfb_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_entry    (q_entry),
        .cfg        (cfg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_byte (frame_byte),
        .last_byte  (last_byte)
    );

endmodule

>>> sv/cfb_checker.sv
// ----------------------------------------------------------------------------
// cfb_checker
// Port-level checks on frame structure, bound to the top level.
// ----------------------------------------------------------------------------
`include "command_frame_builder_crc16_macros.svh"

module cfb_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [7:0]                     frame_byte,
    input logic                           last_byte
);
    import cfb_pkg::*;

    logic [3:0] pos_reg;
    logic       out_xfer;

    assign out_xfer = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (out_xfer)
            pos_reg <= last_byte ? 4'd0 : pos_reg + 1'b1;
    end

    `CFB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(frame_byte) && $stable(last_byte), "stalled output changed")
    `CFB_ASSERT_SAME(a_hdr_a, out_xfer && (pos_reg < 4'd2), frame_byte == HDR_A,
        "bad first header byte")
    `CFB_ASSERT_SAME(a_hdr_b, out_xfer && (pos_reg == 4'd2), frame_byte == HDR_B,
        "bad third header byte")
    `CFB_ASSERT_SAME(a_last_min, out_xfer && last_byte, pos_reg >= 4'd7,
        "frame ended too early")
    `CFB_ASSERT_SAME(a_last_max, out_xfer && (pos_reg == 4'd15), last_byte,
        "frame too long")

endmodule

bind command_frame_builder_crc16 cfb_checker u_cfb_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .frame_byte       (frame_byte),
    .last_byte        (last_byte)
);

>>> tb/command_frame_builder_crc16_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// command_frame_builder_crc16_test
// Drives commands and register writes into the frame builder. It predicts
// every frame byte, including the header, the length, the type byte, the
// parameter pairs and the KERMIT CRC. It checks each byte that the block
// sends, with random idle gaps on the command side and random stalls on the
// byte side.
// ----------------------------------------------------------------------------
module command_frame_builder_crc16_test;

    import cfb_pkg::*;

    localparam int ITEM_TARGET = 270;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_IDLE    = 18;

    localparam int IDLE_NONE   = 0;
    localparam int IDLE_FULL   = 1;
    localparam int IDLE_SPARSE = 2;

    class frame_scoreboard;
        typedef struct {
            logic [7:0] data;
            logic       is_last;
        } frame_byte_t;

        logic [N_W-1:0]        pair_count;
        logic [CFG_DATA_W-1:0] pair_word [PAIR_REGS];
        frame_byte_t           bytes_due [$];
        int                    errors;
        int                    commands;
        int                    bytes_seen;

        function new();
            pair_count = PAIR_COUNT_RST;
            foreach (pair_word[i])
                pair_word[i] = '0;
            pair_word[0] = PAIR_WORD0_RST;
            errors       = 0;
            commands     = 0;
            bytes_seen   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_PAIR_COUNT:
                    pair_count = data[N_W-1:0];
                CFG_PAIR_WORD_0, CFG_PAIR_WORD_1, CFG_PAIR_WORD_2, CFG_PAIR_WORD_3:
                    pair_word[PAIR_IDX_W'(index - CFG_PAIR_WORD_0)] = data;
                default:
                    ;
            endcase
        endfunction

        function logic [15:0] kermit_step(logic [15:0] crc, logic [7:0] b);
            logic [15:0] c;
            c = crc ^ {8'h00, b};
            for (int k = 0; k < 8; k++)
                c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
            return c;
        endfunction

        function void push_byte(logic [7:0] data, logic is_last);
            frame_byte_t fb;
            fb.data    = data;
            fb.is_last = is_last;
            bytes_due.push_back(fb);
        endfunction

        function void note_command(logic [7:0] id, logic [3:0] code);
            logic [7:0]  ty;
            logic [7:0]  param;
            logic [7:0]  value;
            logic [15:0] crc;
            int          n;
            n = (pair_count > PAIR_LIMIT) ? PAIR_LIMIT : int'(pair_count);
            case (code)
                INSTR_DIRECTION: ty = TYPE_DIRECTION;
                INSTR_TURN:      ty = TYPE_TURN;
                INSTR_RESET:     ty = TYPE_RESET;
                default:         ty = TYPE_NONE;
            endcase
            commands++;
            push_byte(HDR_A, 1'b0);
            push_byte(HDR_A, 1'b0);
            push_byte(HDR_B, 1'b0);
            push_byte(8'(5 + 2 * n), 1'b0);
            push_byte(id, 1'b0);
            push_byte(ty, 1'b0);
            crc = kermit_step(kermit_step(16'h0000, id), ty);
            for (int i = 0; i < n; i++) begin
                param = pair_word[i][15:8];
                value = pair_word[i][7:0];
                push_byte(param, 1'b0);
                push_byte(value, 1'b0);
                crc = kermit_step(kermit_step(crc, param), value);
            end
            push_byte(crc[7:0], 1'b0);
            push_byte(crc[15:8], 1'b1);
        endfunction

        function void check_byte(logic [7:0] data, logic is_last);
            frame_byte_t want;
            bytes_seen++;
            if (bytes_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected frame byte %02h, last %0b", $time, data, is_last);
                return;
            end
            want = bytes_due.pop_front();
            if (data !== want.data) begin
                errors++;
                $display("%0t: frame_byte expected %02h actual %02h", $time, want.data, data);
            end
            if (is_last !== want.is_last) begin
                errors++;
                $display("%0t: last_byte expected %0b actual %0b", $time, want.is_last, is_last);
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [7:0]            frame_id;
    logic [3:0]            instruction_code;
    logic                  out_valid;
    logic                  out_ready;
    logic [7:0]            frame_byte;
    logic                  last_byte;

    frame_scoreboard sb;
    int              sender_mode;
    int              receiver_mode;
    int              reg_writes;
    int              settings_used;
    int              cycle_count = 0;

    command_frame_builder_crc16 i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .frame_id         (frame_id),
        .instruction_code (instruction_code),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .frame_byte       (frame_byte),
        .last_byte        (last_byte)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int idle_gap(int mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_FULL: return $urandom_range(0, MAX_IDLE);
            default:   return ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_IDLE) : 0;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CFG_DATA_W'($urandom());
        endcase
    endfunction

    function automatic logic [3:0] random_code();
        if ($urandom_range(0, 1) == 1)
            return 4'($urandom_range(INSTR_DIRECTION, INSTR_RESET));
        return 4'($urandom());
    endfunction

    // all tasks start and end on a falling edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(index, data);
        reg_writes++;
        @(negedge clk);
    endtask

    task automatic apply_settings(input logic [N_W-1:0] count,
                                  input logic [CFG_DATA_W-1:0] w0,
                                  input logic [CFG_DATA_W-1:0] w1,
                                  input logic [CFG_DATA_W-1:0] w2,
                                  input logic [CFG_DATA_W-1:0] w3,
                                  input bit stray);
        write_reg(CFG_PAIR_WORD_0, w0);
        write_reg(CFG_PAIR_WORD_1, w1);
        write_reg(CFG_PAIR_WORD_2, w2);
        write_reg(CFG_PAIR_WORD_3, w3);
        // indexes past the last register must leave everything alone
        if (stray)
            for (int k = CFG_PAIR_WORD_3 + 1; k < 2 ** CFG_IDX_W; k++)
                write_reg(CFG_IDX_W'(k), random_word());
        write_reg(CFG_PAIR_COUNT, count);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic send_command(input logic [7:0] id, input logic [3:0] code);
        int gap;
        gap = idle_gap(sender_mode);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid         <= 1'b1;
        frame_id         <= id;
        instruction_code <= code;
        do @(posedge clk); while (!in_ready);
        sb.note_command(id, code);
        @(negedge clk);
    endtask

    task automatic wait_frames_done();
        in_valid <= 1'b0;
        while (sb.bytes_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // byte sink with random stalls
    initial
    begin
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            stall = idle_gap(receiver_mode);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_byte(frame_byte, last_byte);
            @(negedge clk);
        end
    end

    initial
    begin
        logic [N_W-1:0] count;
        int             len;
        sb               = new();
        sender_mode      = IDLE_FULL;
        receiver_mode    = IDLE_FULL;
        reg_writes       = 0;
        settings_used    = 0;
        rst_n            = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        in_valid         = 1'b0;
        frame_id         = '0;
        instruction_code = '0;
        out_ready        = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults: one pair
        send_command(8'h00, INSTR_DIRECTION);
        send_command(8'hFF, INSTR_TURN);
        send_command(8'h5A, INSTR_RESET);
        send_command(8'h81, 4'h0);
        send_command(8'h3C, 4'hF);

        // no pairs
        wait_frames_done();
        apply_settings('0, PAIR_WORD0_RST, '0, '0, '0, 1'b0);
        send_command(8'hFF, 4'hF);
        send_command(8'h00, INSTR_DIRECTION);

        // all pairs, extreme words
        wait_frames_done();
        apply_settings(N_W'(PAIR_LIMIT), 16'hFFFF, 16'h0000, 16'h8001, 16'h7FFE, 1'b0);
        send_command(8'hFF, INSTR_DIRECTION);
        send_command(8'h00, 4'h0);

        // count above the limit saturates
        wait_frames_done();
        apply_settings('1, 16'h1234, 16'hFEDC, 16'h00FF, 16'hFF00, 1'b0);
        send_command(8'h12, INSTR_TURN);
        send_command(8'hED, INSTR_RESET);

        // writes to unused indexes
        wait_frames_done();
        apply_settings(N_W'(PAIR_LIMIT + 1), 16'hA55A, 16'h5AA5, 16'h0F0F, 16'hF0F0, 1'b1);
        send_command(8'hA5, 4'h4);

        while (sb.commands < ITEM_TARGET) begin
            wait_frames_done();
            sender_mode   = $urandom_range(IDLE_NONE, IDLE_SPARSE);
            receiver_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
            case ($urandom_range(0, 3))
                0:       count = '0;
                1:       count = N_W'(PAIR_LIMIT);
                2:       count = '1;
                default: count = N_W'($urandom());
            endcase
            apply_settings(count, random_word(), random_word(), random_word(), random_word(),
                           $urandom_range(0, 3) == 0);
            len = $urandom_range(24, 40);
            repeat (len) send_command(8'($urandom()), random_code());
        end

        wait_frames_done();
        repeat (32) @(negedge clk);
        if (sb.bytes_due.size() != 0) begin
            $display("%0t: %0d frame bytes never arrived", $time, sb.bytes_due.size());
            sb.errors++;
        end
        $display("covered %0d commands, %0d frame bytes checked", sb.commands, sb.bytes_seen);
        $display("%0d register writes across %0d pair settings", reg_writes, settings_used);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/cfb_pkg.sv
sv/cfb_front.sv
sv/cfb_queue.sv
sv/cfb_back.sv
sv/command_frame_builder_crc16.sv
sv/cfb_checker.sv
tb/command_frame_builder_crc16_test.sv
